// ----- src/cbst_pkg.sv -----
// ----------------------------------------------------------------------------
// cbst_pkg: shared types and constants for the Bezier stroke tessellator
// Holds widths, reset values, the divider request word and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package cbst_pkg;

  // configuration
  localparam logic [15:0] VH_RESET = 16'd1080;

  // segment limits
  localparam logic [6:0] MAX_SEG = 7'd64;

  // shared divider widths
  localparam int NUM_W = 64;
  localparam int DEN_W = 48;

  // request word from the sequencer to the divider
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // clamp a widened sum to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/cubic_bezier_stroke_tessellator.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_stroke_tessellator: cubic Bezier to thick-line quads
// Evaluates the curve at t = i/n and emits one offset quad per segment.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | word
//  in_     | in  | in_tvalid/in_tready   | one curve (312-bit tdata)
//  out_    | out | out_tvalid/out_tready | one quad (296-bit tdata, tlast)
//  cfg_    | in  | cfg_we                | viewport height (16 bit)
//
//  Each segment makes four divisions on the one 64-step divider, a 32-step square
//  root, up to 29 normalising shifts and 13 passes through the shared multiplier.
//  A zero-length segment skips the offset. in_tready is high only when idle.
//  Reset is synchronous; viewport height returns to 1080. A stalled out_tready
//  holds the quad and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_stroke_tessellator (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // p0_x p0_y p1_x p1_y p2_x p2_y p3_x p3_y stroke_color stroke_thickness
  // segment_count, padded to 312 bits
  input  wire logic [311:0] in_tdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // corner0_x corner0_y corner1_x corner1_y corner2_x corner2_y corner3_x
  // corner3_y quad_color segment_number, padded to 296 bits
  output logic [295:0]      out_tdata,
  output logic              out_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_WGT, S_KW, S_MACX, S_DVX, S_DVXW, S_MACY, S_DVY, S_DVYW,
    S_DIFF, S_NORM, S_SQX, S_SQY, S_SQRT, S_DEN, S_MGX, S_DMX, S_DMXW,
    S_MGY, S_DMY, S_DMYW, S_OUT, S_HOLD
  } state_t;

  state_t              state_r;
  logic [15:0]         vh_r;
  logic signed [31:0]  px_r [4];
  logic signed [31:0]  py_r [4];
  logic [31:0]         color_r;
  logic [25:0]         mult_r;
  logic [6:0]          n_r;
  logic [6:0]          i_r;
  logic [11:0]         mm_r;
  logic [12:0]         ii_r;
  logic [18:0]         k_r [4];
  logic [4:0]          cnt_r;
  logic signed [63:0]  acc_r;
  logic                pneg_r;
  logic signed [31:0]  ax_r, ay_r, bx_r, by_r;
  logic [32:0]         sx_r, sy_r;
  logic                sgx_r, sgy_r;
  logic [63:0]         sqv_r;
  logic [35:0]         rem_r;
  logic [31:0]         root_r;
  logic [47:0]         den_r;
  logic signed [31:0]  ox_r, oy_r;
  logic [295:0]        odata_r;
  logic                olast_r;
  logic                ovalid_r;

  // ---- shared multiplier ----
  logic signed [33:0]  mul_a, mul_b;
  logic signed [67:0]  prod_w;
  logic signed [63:0]  prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MACX: begin
        mul_a = $signed({15'd0, k_r[cnt_r[1:0]]});
        mul_b = 34'(px_r[cnt_r[1:0]]);
      end
      S_MACY: begin
        mul_a = $signed({15'd0, k_r[cnt_r[1:0]]});
        mul_b = 34'(py_r[cnt_r[1:0]]);
      end
      S_SQX: begin
        mul_a = $signed({1'b0, sx_r});
        mul_b = $signed({1'b0, sx_r});
      end
      S_SQY: begin
        mul_a = $signed({1'b0, sy_r});
        mul_b = $signed({1'b0, sy_r});
      end
      S_DEN: begin
        mul_a = $signed({18'd0, (vh_r == 16'd0) ? 16'd1 : vh_r});
        mul_b = $signed({2'd0, root_r});
      end
      S_MGX: begin
        mul_a = $signed({1'b0, sx_r});
        mul_b = $signed({8'd0, mult_r});
      end
      S_MGY: begin
        mul_a = $signed({1'b0, sy_r});
        mul_b = $signed({8'd0, mult_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_w = mul_a * mul_b;
  assign prod   = prod_w[63:0];

  // ---- point rounding: floor((acc + n3/2) / n3) ----
  logic [18:0]         n3;
  logic signed [63:0]  rx;
  logic [63:0]         ux;
  logic                rneg;

  assign n3   = k_r[0] + k_r[1] + k_r[2] + k_r[3];
  assign rx   = acc_r + $signed({46'd0, n3[18:1]});
  assign rneg = rx[63];
  assign ux   = rneg ? 64'(-rx) : 64'(rx);

  // ---- divider requests ----
  cbst_pkg::div_req_t dreq;
  logic               ddone;
  logic [63:0]        dquot;

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    case (state_r) inside
      S_DVX, S_DVY: begin
        dreq.start = 1'b1;
        dreq.num   = rneg ? (ux + {45'd0, n3} - 64'd1) : ux;
        dreq.den   = {29'd0, n3};
      end
      S_DMX, S_DMY: begin
        dreq.start = 1'b1;
        dreq.num   = 64'(acc_r) + {17'd0, den_r[47:1]};
        dreq.den   = den_r;
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  cbst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .done  (ddone),
    .quot  (dquot)
  );

  // ---- small helpers for the sequencer ----
  logic [6:0]          m_w;
  logic [6:0]          n_in;
  logic signed [32:0]  dx_w, dy_w;
  logic [32:0]         mx_w;
  logic signed [31:0]  pt_w;
  logic [35:0]         rem_t, trial;
  logic [31:0]         mag_w;
  logic [6:0]          seg_in;

  assign m_w    = n_r - i_r;
  assign seg_in = in_tdata[310:304];
  assign n_in   = (seg_in == 7'd0) ? 7'd1 :
                  (seg_in > cbst_pkg::MAX_SEG) ? cbst_pkg::MAX_SEG : seg_in;
  assign dx_w   = 33'(by_r) - 33'(ay_r);
  assign dy_w   = 33'(ax_r) - 33'(bx_r);
  assign mx_w   = (sx_r > sy_r) ? sx_r : sy_r;
  assign pt_w   = pneg_r ? 32'(-dquot[31:0]) : dquot[31:0];
  assign rem_t  = {rem_r[33:0], sqv_r[63:62]};
  assign trial  = {2'd0, root_r, 2'b01};
  assign mag_w  = dquot[31:0];

  // ---- corners ----
  logic signed [33:0]  c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;

  assign c0x = 34'(ax_r) + 34'(ox_r);
  assign c0y = 34'(ay_r) + 34'(oy_r);
  assign c1x = 34'(bx_r) + 34'(ox_r);
  assign c1y = 34'(by_r) + 34'(oy_r);
  assign c2x = 34'(bx_r) - 34'(ox_r);
  assign c2y = 34'(by_r) - 34'(oy_r);
  assign c3x = 34'(ax_r) - 34'(ox_r);
  assign c3y = 34'(ay_r) - 34'(oy_r);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_r <= cbst_pkg::VH_RESET;
    end else if (cfg_we) begin
      vh_r <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
      i_r      <= 7'd1;
      n_r      <= 7'd1;
    end else begin
      unique case (state_r) inside
        S_IDLE: begin
          if (in_tvalid) begin
            for (int k = 0; k < 4; k++) begin
              px_r[k] <= in_tdata[64*k +: 32];
              py_r[k] <= in_tdata[64*k+32 +: 32];
            end
            ax_r    <= in_tdata[31:0];
            ay_r    <= in_tdata[63:32];
            color_r <= in_tdata[287:256];
            mult_r  <= {1'b0, in_tdata[303:288], 9'd0} + {2'd0, in_tdata[303:288], 8'd0};
            n_r     <= n_in;
            i_r     <= 7'd1;
            state_r <= S_WGT;
          end
        end
        S_WGT: begin
          mm_r    <= 12'(m_w[5:0] * m_w[5:0]);
          ii_r    <= 13'(i_r * i_r);
          state_r <= S_KW;
        end
        S_KW: begin
          k_r[0]  <= 19'(mm_r * m_w[5:0]);
          k_r[1]  <= 19'(mm_r * i_r) + (19'(mm_r * i_r) << 1);
          k_r[2]  <= 19'(ii_r * m_w[5:0]) + (19'(ii_r * m_w[5:0]) << 1);
          k_r[3]  <= 19'(ii_r * i_r);
          acc_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_MACX;
        end
        S_MACX, S_MACY: begin
          acc_r <= acc_r + prod;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r[1:0] == 2'd3) begin
            state_r <= (state_r == S_MACX) ? S_DVX : S_DVY;
          end
        end
        S_DVX, S_DVY: begin
          pneg_r  <= rneg;
          state_r <= (state_r == S_DVX) ? S_DVXW : S_DVYW;
        end
        S_DVXW: begin
          if (ddone) begin
            bx_r    <= pt_w;
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_MACY;
          end
        end
        S_DVYW: begin
          if (ddone) begin
            by_r    <= pt_w;
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          sgx_r   <= dx_w[32];
          sgy_r   <= dy_w[32];
          sx_r    <= dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
          sy_r    <= dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
          state_r <= S_NORM;
        end
        S_NORM: begin
          // zero length: no offset; large: scale down by four; else shift up
          if (mx_w == 33'd0) begin
            ox_r    <= '0;
            oy_r    <= '0;
            state_r <= S_OUT;
          end else if (mx_w[32:31] != 2'd0) begin
            sx_r    <= sx_r >> 2;
            sy_r    <= sy_r >> 2;
            state_r <= S_SQX;
          end else if (mx_w[30:29] == 2'd0) begin
            sx_r <= sx_r << 1;
            sy_r <= sy_r << 1;
          end else begin
            state_r <= S_SQX;
          end
        end
        S_SQX: begin
          acc_r   <= prod;
          state_r <= S_SQY;
        end
        S_SQY: begin
          sqv_r   <= 64'(acc_r + prod);
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          // one root bit per step from the top pair of bits
          sqv_r <= {sqv_r[61:0], 2'b00};
          if (rem_t >= trial) begin
            rem_r  <= rem_t - trial;
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rem_r  <= rem_t;
            root_r <= {root_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= S_DEN;
          end
        end
        S_DEN: begin
          den_r   <= prod[47:0];
          state_r <= S_MGX;
        end
        S_MGX: begin
          acc_r   <= prod;
          state_r <= S_DMX;
        end
        S_DMX: begin
          state_r <= S_DMXW;
        end
        S_DMXW: begin
          if (ddone) begin
            ox_r    <= sgx_r ? 32'(-mag_w) : mag_w;
            state_r <= S_MGY;
          end
        end
        S_MGY: begin
          acc_r   <= prod;
          state_r <= S_DMY;
        end
        S_DMY: begin
          state_r <= S_DMYW;
        end
        S_DMYW: begin
          if (ddone) begin
            oy_r    <= sgy_r ? 32'(-mag_w) : mag_w;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          odata_r  <= {1'b0, i_r, color_r,
                       cbst_pkg::sat32(c3y), cbst_pkg::sat32(c3x),
                       cbst_pkg::sat32(c2y), cbst_pkg::sat32(c2x),
                       cbst_pkg::sat32(c1y), cbst_pkg::sat32(c1x),
                       cbst_pkg::sat32(c0y), cbst_pkg::sat32(c0x)};
          olast_r  <= (i_r == n_r);
          ovalid_r <= 1'b1;
          state_r  <= S_HOLD;
        end
        S_HOLD: begin
          if (out_tready) begin
            ovalid_r <= 1'b0;
            if (i_r == n_r) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 7'd1;
              ax_r    <= bx_r;
              ay_r    <= by_r;
              state_r <= S_WGT;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

`ifndef SYNTHESIS
  // no new curve while a quad is on offer
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a quad is pending");

  // a taken curve blocks the input on the next edge
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still ready after a curve was taken");

  // segment number never exceeds the clamped count
  a_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[294:288] <= n_r && out_tdata[294:288] != 7'd0))
    else $error("segment number out of range");

  // last flag marks exactly the final segment
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[294:288] == n_r)))
    else $error("last flag disagrees with segment number");
`endif

endmodule

`default_nettype wire

// ----- src/cbst_div.sv -----
// ----------------------------------------------------------------------------
// cbst_div: restoring unsigned divider
// One quotient bit per cycle, full numerator width; done pulses with quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module cbst_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cbst_pkg::div_req_t        req,
  output logic                           done,
  output logic [cbst_pkg::NUM_W-1:0]     quot
);

  logic                          busy_r;
  logic [5:0]                    cnt_r;
  logic [cbst_pkg::NUM_W-1:0]    num_r;
  logic [cbst_pkg::DEN_W-1:0]    rem_r;
  logic [cbst_pkg::DEN_W-1:0]    den_r;
  logic                          done_r;

  logic [cbst_pkg::DEN_W:0]      rem_t;
  logic                          take;

  // trial subtract for the next quotient bit
  assign rem_t = {rem_r, num_r[cbst_pkg::NUM_W-1]};
  assign take  = (rem_t >= {1'b0, den_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: numerator shifts out, quotient shifts in
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      if (take) begin
        rem_r <= cbst_pkg::DEN_W'(rem_t - {1'b0, den_r});
      end else begin
        rem_r <= rem_t[cbst_pkg::DEN_W-1:0];
      end
      num_r <= {num_r[cbst_pkg::NUM_W-2:0], take};
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

`default_nettype wire

// ----- sim/tb_cubic_bezier_stroke_tessellator.sv -----
// ----------------------------------------------------------------------------
// tb_cubic_bezier_stroke_tessellator: self-checking bench for the tessellator
// Drives curves over the in_ stream, predicts every quad in fixed point and
// compares each out_ word field by field, under random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cubic_bezier_stroke_tessellator;

  typedef struct packed {
    logic [6:0]  seg_count;
    logic [15:0] thick;
    logic [31:0] colour;
    logic [31:0] p3y, p3x, p2y, p2x, p1y, p1x, p0y, p0x;
  } curve_t;

  typedef struct {
    logic [31:0] c [8];
    logic [31:0] colour;
    logic [6:0]  seg_no;
    logic        last;
  } quad_t;

  logic         clk;
  logic         rst_n;
  logic [311:0] in_tdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [295:0] out_tdata;
  logic         out_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_we;
  logic [15:0]  cfg_wdata;

  logic [15:0] vp_height;
  quad_t       quad_q[$];
  int          n_errors;
  int          n_curves;
  int          n_quads;
  bit          rx_idle_en;
  bit          hold_off;

  cubic_bezier_stroke_tessellator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // rounded division, ties toward +inf
  function automatic longint div_rnd(longint num, longint den);
    longint x, q;
    x = num + den / 2;
    q = x / den;
    if ((x % den) != 0 && x < 0) q--;
    return q;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // perpendicular offset scaled by 768*thickness/height
  task automatic stroke_offset(input longint px, input longint py,
                               input longint unsigned mult,
                               input longint unsigned h,
                               output longint ox, output longint oy);
    longint unsigned sx, sy, len, den, mag;
    sx = px < 0 ? -px : px;
    sy = py < 0 ? -py : py;
    ox = 0;
    oy = 0;
    if (sx == 0 && sy == 0) return;
    if ((sx > sy ? sx : sy) >= (64'd1 << 31)) begin
      sx >>= 2;
      sy >>= 2;
    end else begin
      while ((sx > sy ? sx : sy) < (64'd1 << 29)) begin
        sx <<= 1;
        sy <<= 1;
      end
    end
    len = sqrt_floor(sx * sx + sy * sy);
    den = h * len;
    if (den == 0) return;
    mag = (sx * mult + den / 2) / den;
    ox = px < 0 ? -longint'(mag) : longint'(mag);
    mag = (sy * mult + den / 2) / den;
    oy = py < 0 ? -longint'(mag) : longint'(mag);
  endtask

  // expand one curve into its expected quads
  task automatic predict_quads(input curve_t cv);
    longint x[4], y[4];
    longint n, n3, ax, ay, bx, by, m, k1, k2, k3, k4, ox, oy;
    longint unsigned mult, h;
    quad_t q;
    x[0] = signed'(cv.p0x); y[0] = signed'(cv.p0y);
    x[1] = signed'(cv.p1x); y[1] = signed'(cv.p1y);
    x[2] = signed'(cv.p2x); y[2] = signed'(cv.p2y);
    x[3] = signed'(cv.p3x); y[3] = signed'(cv.p3y);
    mult = 768 * cv.thick;
    h = vp_height == 0 ? 1 : vp_height;
    n = cv.seg_count;
    if (n == 0) n = 1;
    if (n > cbst_pkg::MAX_SEG) n = cbst_pkg::MAX_SEG;
    n3 = n * n * n;
    ax = x[0];
    ay = y[0];
    for (longint i = 1; i <= n; i++) begin
      m = n - i;
      k1 = m * m * m; k2 = 3 * m * m * i; k3 = 3 * m * i * i; k4 = i * i * i;
      bx = div_rnd(k1 * x[0] + k2 * x[1] + k3 * x[2] + k4 * x[3], n3);
      by = div_rnd(k1 * y[0] + k2 * y[1] + k3 * y[2] + k4 * y[3], n3);
      stroke_offset(by - ay, ax - bx, mult, h, ox, oy);
      q.c[0] = clamp32(ax + ox); q.c[1] = clamp32(ay + oy);
      q.c[2] = clamp32(bx + ox); q.c[3] = clamp32(by + oy);
      q.c[4] = clamp32(bx - ox); q.c[5] = clamp32(by - oy);
      q.c[6] = clamp32(ax - ox); q.c[7] = clamp32(ay - oy);
      q.colour = cv.colour;
      q.seg_no = i[6:0];
      q.last = (i == n);
      quad_q.insert(quad_q.size(), q);
      ax = bx;
      ay = by;
    end
  endtask

  // send one curve word, predicting at acceptance; valid stays up for the next
  task automatic send_curve(input curve_t cv, input bit gaps = 1);
    if (gaps) begin
      while ($urandom_range(99) < 10) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tdata <= {cv.seg_count, cv.thick, cv.colour, cv.p3y, cv.p3x, cv.p2y,
                 cv.p2x, cv.p1y, cv.p1x, cv.p0y, cv.p0x};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_quads(cv);
    n_curves++;
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (quad_q.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
  endtask

  task automatic write_height(input logic [15:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    vp_height = v;
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      1: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic curve_t rnd_curve;
    curve_t cv;
    int mode;
    mode = $urandom_range(2);
    cv.p0x = rnd_coord(mode); cv.p0y = rnd_coord(mode);
    cv.p1x = rnd_coord(mode); cv.p1y = rnd_coord(mode);
    cv.p2x = rnd_coord(mode); cv.p2y = rnd_coord(mode);
    cv.p3x = rnd_coord(mode); cv.p3y = rnd_coord(mode);
    cv.colour = $urandom;
    cv.thick = $urandom;
    // mostly short curves, now and then long or out of range
    case ($urandom_range(9))
      0: cv.seg_count = $urandom_range(127);
      1: cv.seg_count = $urandom_range(64, 40);
      default: cv.seg_count = $urandom_range(6);
    endcase
    return cv;
  endfunction

  // directed extremes and special cases
  task automatic test_directed;
    curve_t cv;
    cv = '0;
    cv.colour = 32'hDEAD_BEEF; cv.thick = 16'h0100;
    send_curve(cv);                              // zero length, zero count
    cv.p3x = 32'h0010_0000; cv.seg_count = 7'd1;
    send_curve(cv);
    cv.p0x = 32'h8000_0000; cv.p0y = 32'h7FFF_FFFF;
    cv.p1x = 32'h7FFF_FFFF; cv.p1y = 32'h8000_0000;
    cv.p2x = 32'h8000_0000; cv.p2y = 32'h8000_0000;
    cv.p3x = 32'h7FFF_FFFF; cv.p3y = 32'h7FFF_FFFF;
    cv.thick = 16'hFFFF; cv.colour = 32'hFFFF_FFFF; cv.seg_count = 7'd3;
    send_curve(cv);                              // saturating corners
    cv.seg_count = 7'd127;                       // clamped to the maximum
    send_curve(cv);
    cv.seg_count = 7'd64; cv.thick = 16'h0000; cv.colour = '0;
    send_curve(cv);
    cv.p0x = 32'h0001_0000; cv.p0y = 32'h0001_0000;
    cv.p1x = 32'h0001_0000; cv.p1y = 32'h0001_0000;
    cv.p2x = 32'h0001_0000; cv.p2y = 32'h0001_0000;
    cv.p3x = 32'h0001_0000; cv.p3y = 32'h0001_0000;
    cv.thick = 16'h0280; cv.seg_count = 7'd4;
    send_curve(cv);                              // degenerate point curve
    for (int k = 0; k < 6; k++) send_curve(rnd_curve());
  endtask

  task automatic test_heights;
    logic [15:0] hv [4];
    hv = '{16'd1, 16'd65535, 16'd0, 16'd480};
    foreach (hv[k]) begin
      write_height(hv[k]);
      repeat (4) send_curve(rnd_curve());
    end
  endtask

  // long receiver hold-off while curves keep coming
  task automatic test_backpressure;
    write_height(16'd720);
    hold_off = 1'b1;
    repeat (6) send_curve(rnd_curve(), 0);
    hold_off = 1'b0;
  endtask

  task automatic test_random;
    for (int k = 0; k < 226; k++) begin
      rx_idle_en = !(k >= 60 && k < 100);
      if (k == 100) write_height(16'd1080);
      send_curve(rnd_curve(), rx_idle_en);
    end
    rx_idle_en = 1'b1;
  endtask

  // receiver ready: random idling, plus a counted long stall
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      out_tready <= !(rx_idle_en && $urandom_range(99) < 10);
    end
  end

  // quad checker
  always @(posedge clk) begin
    quad_t e;
    logic [31:0] got;
    if (rst_n && out_tvalid && out_tready) begin
      n_quads++;
      if (quad_q.size() == 0) begin
        $error("unexpected quad %h", out_tdata);
        n_errors++;
      end else begin
        e = quad_q.pop_front();
        for (int k = 0; k < 8; k++) begin
          got = out_tdata[32*k +: 32];
          if (got !== e.c[k]) begin
            $error("corner%0d_%s exp %h got %h", k / 2, k[0] ? "y" : "x", e.c[k], got);
            n_errors++;
          end
        end
        if (out_tdata[287:256] !== e.colour) begin
          $error("quad_color exp %h got %h", e.colour, out_tdata[287:256]);
          n_errors++;
        end
        if (out_tdata[294:288] !== e.seg_no) begin
          $error("segment_number exp %0d got %0d", e.seg_no, out_tdata[294:288]);
          n_errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last_segment exp %b got %b", e.last, out_tlast);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("tb_cubic_bezier_stroke_tessellator: errors");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    vp_height = cbst_pkg::VH_RESET;
    n_errors = 0;
    n_curves = 0;
    n_quads = 0;
    rx_idle_en = 1'b1;
    hold_off = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_heights();
    test_backpressure();
    test_random();
    drain();
    if (quad_q.size() != 0) begin
      $error("%0d quads never arrived", quad_q.size());
      n_errors++;
    end
    $display("covered %0d curves, %0d quads, heights 1..65535 and zero, long stall",
             n_curves, n_quads);
    if (n_errors == 0) begin
      $display("tb_cubic_bezier_stroke_tessellator: clean");
    end else begin
      $display("tb_cubic_bezier_stroke_tessellator: errors");
    end
    $finish;
  end

endmodule
